// File: hdl/cti_pkg.sv
// ----------------------------------------------------------------------------
// cti_pkg
// shared constants, stage types and helpers of the cubic trajectory block
// ----------------------------------------------------------------------------
package cti_pkg;

  localparam int FRAC_BITS   = 16;
  // quotient bits of the long divider, enough for both divisions
  localparam int DIV_K       = (32 + FRAC_BITS > 48) ? 32 + FRAC_BITS : 48;
  localparam int VEL_CAP_LOG = 47;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_IDX = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_IDX  = CFG_IDX_W'(1);

  typedef struct packed {
    logic               lo;
    logic               hi;
    logic signed [31:0] p0;
    logic signed [31:0] v0;
    logic signed [31:0] p1;
    logic signed [31:0] v1;
    logic signed [31:0] pos;
    logic               neg;
    logic               cap;
  } cti_side_t;

  typedef struct packed {
    logic [31:0]      rem;
    logic [DIV_K-1:0] quo;
    logic [DIV_K-1:0] bits;
    logic [31:0]      t;
    cti_side_t        side;
  } cti_dstage_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/cti_div.sv
// ----------------------------------------------------------------------------
// cti_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module cti_div
  import cti_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cti_dstage_t in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cti_dstage_t out_o
);

  logic        vld_q [DIV_K];
  logic        vsrc  [DIV_K];
  logic        adv   [DIV_K+1];
  cti_dstage_t src   [DIV_K];
  cti_dstage_t st_d  [DIV_K];
  cti_dstage_t st_q  [DIV_K];

  assign adv[DIV_K] = out_ready_i;

  for (genvar i = 0; i < DIV_K; i++) begin : g_stage
    logic [32:0] trial;
    logic        take;

    if (i == 0) begin : g_first
      assign src[i]  = in_i;
      assign vsrc[i] = in_valid_i;
    end else begin : g_next
      assign src[i]  = st_q[i-1];
      assign vsrc[i] = vld_q[i-1];
    end

    assign adv[i] = !vld_q[i] || adv[i+1];

    always_comb begin
      trial = {src[i].rem, src[i].bits[DIV_K-1]};
      take  = trial >= {1'b0, src[i].t};
      st_d[i]      = src[i];
      st_d[i].rem  = take ? 32'(trial - {1'b0, src[i].t}) : trial[31:0];
      st_d[i].quo  = {src[i].quo[DIV_K-2:0], take};
      st_d[i].bits = src[i].bits << 1;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (adv[i]) begin
        vld_q[i] <= vsrc[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[i]) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[DIV_K-1];
  assign out_o       = st_q[DIV_K-1];

endmodule

// File: hdl/cti_poly.sv
// ----------------------------------------------------------------------------
// cti_poly
// hermite coefficient and polynomial pipeline between the two dividers
// ----------------------------------------------------------------------------
module cti_poly
  import cti_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cti_dstage_t in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cti_dstage_t out_o
);

  localparam int NS = 11;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } sm_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] lp;
    logic [63:0] hp;
  } mfp_t;

  function automatic sm_t to_sm(input logic signed [63:0] x);
    sm_t r;
    r.neg = x[63];
    r.mag = x[63] ? 64'(-x) : 64'(x);
    return r;
  endfunction

  function automatic logic signed [63:0] to_sg(input sm_t a);
    logic signed [63:0] r;
    r = a.neg ? -$signed(a.mag) : $signed(a.mag);
    return r;
  endfunction

  function automatic mfp_t mf_prod(input sm_t a, input logic [31:0] u);
    mfp_t r;
    r.neg = a.neg;
    r.lp  = a.mag[31:0] * u;
    r.hp  = a.mag[63:32] * u;
    return r;
  endfunction

  // magnitude of the floored product, rounding away from zero when negative
  function automatic sm_t mf_sum(input mfp_t p);
    sm_t r;
    r.neg = p.neg;
    r.mag = p.hp + 64'(p.lp[63:32]) + 64'(p.neg && (p.lp[31:0] != 32'd0));
    return r;
  endfunction

  logic v_q [NS];
  logic adv [NS+1];

  always_comb begin
    adv[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 1: time products and position delta
  cti_side_t          side1_q;
  logic [31:0]        t1_q, u1_q;
  logic signed [63:0] pv0_1_q, pv1_1_q;
  logic signed [32:0] dp1_q;
  logic signed [64:0] pv0_full, pv1_full;

  assign pv0_full = in_i.side.v0 * $signed({1'b0, in_i.t});
  assign pv1_full = in_i.side.v1 * $signed({1'b0, in_i.t});

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      side1_q <= in_i.side;
      t1_q    <= in_i.t;
      u1_q    <= in_i.quo[DIV_K-1 -: 32];
      pv0_1_q <= pv0_full[63:0];
      pv1_1_q <= pv1_full[63:0];
      dp1_q   <= $signed({in_i.side.p1[31], in_i.side.p1})
               - $signed({in_i.side.p0[31], in_i.side.p0});
    end
  end

  // stage 2: coefficients
  cti_side_t          side2_q;
  logic [31:0]        t2_q, u2_q;
  logic signed [63:0] vt0_2_q, c2_2_q, c3_2_q;
  logic signed [63:0] vt0_d, vt1_d, dp64;

  always_comb begin
    vt0_d = pv0_1_q >>> FRAC_BITS;
    vt1_d = pv1_1_q >>> FRAC_BITS;
    dp64  = 64'(dp1_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      side2_q <= side1_q;
      t2_q    <= t1_q;
      u2_q    <= u1_q;
      vt0_2_q <= vt0_d;
      c2_2_q  <= (dp64 <<< 1) + dp64 - (vt0_d <<< 1) - vt1_d;
      c3_2_q  <= vt0_d + vt1_d - (dp64 <<< 1);
    end
  end

  // stage 3: sign and magnitude
  cti_side_t   side3_q;
  logic [31:0] t3_q, u3_q;
  sm_t         a_vt0_3_q, a_c2_3_q, a_c3_3_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      side3_q   <= side2_q;
      t3_q      <= t2_q;
      u3_q      <= u2_q;
      a_vt0_3_q <= to_sm(vt0_2_q);
      a_c2_3_q  <= to_sm(c2_2_q);
      a_c3_3_q  <= to_sm(c3_2_q);
    end
  end

  // stage 4: first products
  cti_side_t   side4_q;
  logic [31:0] t4_q, u4_q;
  mfp_t        p_vt0_4_q, p_c2_4_q, p_c3_4_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      side4_q   <= side3_q;
      t4_q      <= t3_q;
      u4_q      <= u3_q;
      p_vt0_4_q <= mf_prod(a_vt0_3_q, u3_q);
      p_c2_4_q  <= mf_prod(a_c2_3_q, u3_q);
      p_c3_4_q  <= mf_prod(a_c3_3_q, u3_q);
    end
  end

  // stage 5
  cti_side_t   side5_q;
  logic [31:0] t5_q, u5_q;
  sm_t         vt0u_5_q, c2u_5_q, c3u_5_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      side5_q  <= side4_q;
      t5_q     <= t4_q;
      u5_q     <= u4_q;
      vt0u_5_q <= mf_sum(p_vt0_4_q);
      c2u_5_q  <= mf_sum(p_c2_4_q);
      c3u_5_q  <= mf_sum(p_c3_4_q);
    end
  end

  // stage 6: second products
  cti_side_t   side6_q;
  logic [31:0] t6_q, u6_q;
  sm_t         vt0u_6_q, c2u_6_q;
  mfp_t        p_c2u_6_q, p_c3u_6_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      side6_q   <= side5_q;
      t6_q      <= t5_q;
      u6_q      <= u5_q;
      vt0u_6_q  <= vt0u_5_q;
      c2u_6_q   <= c2u_5_q;
      p_c2u_6_q <= mf_prod(c2u_5_q, u5_q);
      p_c3u_6_q <= mf_prod(c3u_5_q, u5_q);
    end
  end

  // stage 7
  cti_side_t   side7_q;
  logic [31:0] t7_q, u7_q;
  sm_t         vt0u_7_q, c2u_7_q, c2uu_7_q, c3uu_7_q;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      side7_q  <= side6_q;
      t7_q     <= t6_q;
      u7_q     <= u6_q;
      vt0u_7_q <= vt0u_6_q;
      c2u_7_q  <= c2u_6_q;
      c2uu_7_q <= mf_sum(p_c2u_6_q);
      c3uu_7_q <= mf_sum(p_c3u_6_q);
    end
  end

  // stage 8: third product, signed terms
  cti_side_t          side8_q;
  logic [31:0]        t8_q;
  mfp_t               p_c3uu_8_q;
  logic signed [63:0] vt0u_8_q, c2u_8_q, c2uu_8_q, c3uu_8_q;

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      side8_q    <= side7_q;
      t8_q       <= t7_q;
      p_c3uu_8_q <= mf_prod(c3uu_7_q, u7_q);
      vt0u_8_q   <= to_sg(vt0u_7_q);
      c2u_8_q    <= to_sg(c2u_7_q);
      c2uu_8_q   <= to_sg(c2uu_7_q);
      c3uu_8_q   <= to_sg(c3uu_7_q);
    end
  end

  // stage 9: partial position and velocity numerator
  cti_side_t          side9_q;
  logic [31:0]        t9_q;
  sm_t                c3uuu_9_q;
  logic signed [63:0] w_9_q, part_9_q;

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      side9_q   <= side8_q;
      t9_q      <= t8_q;
      c3uuu_9_q <= mf_sum(p_c3uu_8_q);
      w_9_q     <= (c2u_8_q <<< 1) + (c3uu_8_q <<< 1) + c3uu_8_q;
      part_9_q  <= 64'(side8_q.p0) + vt0u_8_q + c2uu_8_q;
    end
  end

  // stage 10
  cti_side_t          side10_q;
  logic [31:0]        t10_q;
  logic signed [63:0] sc3uuu_10_q, part_10_q;
  logic [63:0]        mw_10_q;
  logic               nw_10_q;
  logic [79:0]        lim_10_q;
  sm_t                w_sm;

  assign w_sm = to_sm(w_9_q);

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      side10_q    <= side9_q;
      t10_q       <= t9_q;
      sc3uuu_10_q <= to_sg(c3uuu_9_q);
      part_10_q   <= part_9_q;
      mw_10_q     <= w_sm.mag;
      nw_10_q     <= w_sm.neg;
      lim_10_q    <= ({48'd0, t9_q} << (VEL_CAP_LOG - FRAC_BITS)) + {48'd0, t9_q};
    end
  end

  // stage 11: position result, divider operands
  cti_dstage_t              out_d, out_q;
  logic [63+FRAC_BITS:0]    dw;

  always_comb begin
    dw             = {mw_10_q, {FRAC_BITS{1'b0}}};
    out_d.rem      = 32'(dw >> DIV_K);
    out_d.quo      = '0;
    out_d.bits     = dw[DIV_K-1:0];
    out_d.t        = t10_q;
    out_d.side     = side10_q;
    out_d.side.pos = sat32(part_10_q + sc3uuu_10_q);
    out_d.side.neg = nw_10_q;
    out_d.side.cap = {16'd0, mw_10_q} >= lim_10_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[10]) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];
  assign out_o       = out_q;

endmodule

// File: hdl/cubic_trajectory_interpolator_top.sv
// ----------------------------------------------------------------------------
// cubic_trajectory_interpolator_top
// cubic hermite position and velocity of one axis per item, q16.16
// ----------------------------------------------------------------------------
// the config channel writes the segment start time (index 0) and goal time
// (index 1); it is always ready and writes to other indexes are dropped.
// an input item carries the current time and the start and goal position
// and velocity of one axis; each item gives one result item with position,
// velocity and the done flag.
// one item enters per cycle while in_stall_o is low. the stages are one
// front stage, a DIV_K stage pipelined restoring divider for the
// segment fraction, eleven coefficient and polynomial stages, a second
// DIV_K stage divider for the velocity term, then two output stages.
// every stage holds its own valid bit; a stall on the output only backs up
// the filled stages, so empty stages keep taking items until the pipeline
// is full, then in_stall_o rises. nothing is lost or repeated.
// reset empties the pipeline and clears both times to zero.
// ----------------------------------------------------------------------------
module cubic_trajectory_interpolator_top
  import cti_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [31:0]          now_time_i,
  input  logic signed [31:0]   begin_pos_i,
  input  logic signed [31:0]   begin_vel_i,
  input  logic signed [31:0]   end_pos_i,
  input  logic signed [31:0]   end_vel_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   pos_out_o,
  output logic signed [31:0]   vel_out_o,
  output logic                 done_flag_o
);

  logic [31:0] start_q, goal_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      goal_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_IDX: start_q <= cfg_data_i;
        CFG_GOAL_IDX:  goal_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front stage
  logic        adv_s0, v_s0_q;
  cti_dstage_t s0_d, s0_q;
  logic        div1_ready, div1_valid, poly_ready, poly_valid;
  logic        div2_ready, div2_valid;
  cti_dstage_t div1_out, poly_out, div2_out;

  always_comb begin
    s0_d           = '0;
    s0_d.rem       = now_time_i - start_q;
    s0_d.t         = goal_q - start_q;
    s0_d.side.lo   = now_time_i <= start_q;
    s0_d.side.hi   = now_time_i >= goal_q;
    s0_d.side.p0   = begin_pos_i;
    s0_d.side.v0   = begin_vel_i;
    s0_d.side.p1   = end_pos_i;
    s0_d.side.v1   = end_vel_i;
  end

  assign adv_s0     = !v_s0_q || div1_ready;
  assign in_stall_o = !adv_s0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s0_q <= 1'b0;
    end else if (adv_s0) begin
      v_s0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s0) begin
      s0_q <= s0_d;
    end
  end

  cti_div u_div_frac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_s0_q),
    .in_ready_o  (div1_ready),
    .in_i        (s0_q),
    .out_valid_o (div1_valid),
    .out_ready_i (poly_ready),
    .out_o       (div1_out)
  );

  cti_poly u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div1_valid),
    .in_ready_o  (poly_ready),
    .in_i        (div1_out),
    .out_valid_o (poly_valid),
    .out_ready_i (div2_ready),
    .out_o       (poly_out)
  );

  logic adv_f1, adv_out;

  cti_div u_div_vel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (poly_valid),
    .in_ready_o  (div2_ready),
    .in_i        (poly_out),
    .out_valid_o (div2_valid),
    .out_ready_i (adv_f1),
    .out_o       (div2_out)
  );

  // velocity term with cap and floor
  logic               v_f1_q;
  cti_side_t          side_f1_q;
  logic signed [63:0] sdt_d, sdt_f1_q;
  logic [63:0]        res;
  logic               inexact;

  always_comb begin
    res     = div2_out.side.cap ? (64'd1 << VEL_CAP_LOG) : 64'(div2_out.quo);
    inexact = !div2_out.side.cap && (div2_out.rem != 32'd0);
    sdt_d   = div2_out.side.neg ? $signed(~res + 64'(!inexact)) : $signed(res);
  end

  assign adv_out = !out_valid_o || !out_stall_i;
  assign adv_f1  = !v_f1_q || adv_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_f1_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (adv_f1) begin
        v_f1_q <= div2_valid;
      end
      if (adv_out) begin
        out_valid_o <= v_f1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_f1) begin
      side_f1_q <= div2_out.side;
      sdt_f1_q  <= sdt_d;
    end
  end

  // output register
  logic signed [31:0] pos_d, vel_d;

  always_comb begin
    if (side_f1_q.lo) begin
      pos_d = side_f1_q.p0;
      vel_d = side_f1_q.v0;
    end else if (side_f1_q.hi) begin
      pos_d = side_f1_q.p1;
      vel_d = side_f1_q.v1;
    end else begin
      pos_d = side_f1_q.pos;
      vel_d = sat32(64'(side_f1_q.v0) + sdt_f1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      pos_out_o   <= pos_d;
      vel_out_o   <= vel_d;
      done_flag_o <= side_f1_q.hi;
    end
  end

endmodule
